[rtl/jts_pkg.sv]
// Shared types and constants of the JSON token scanner.
`default_nettype none

package jts_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_SKIP   = 3'd3,
    MODE_MINUS  = 3'd4
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_STR_CHAR = 3'd1,
    KIND_STR_END  = 3'd2,
    KIND_INT      = 3'd3,
    KIND_TRUE     = 3'd4,
    KIND_FALSE    = 3'd5
  } token_kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam logic [2:0]  SKIP_TRUE  = 3'd3;
  localparam logic [2:0]  SKIP_FALSE = 3'd4;
  localparam logic [3:0]  RADIX      = 4'd10;
  localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    scan_mode_t  mode;
    logic [2:0]  skip;
    logic [31:0] acc;
    logic        neg;
    logic        sat;
  } scan_state_t;

  typedef struct packed {
    token_kind_t        kind;
    logic [7:0]         char_value;
    logic signed [31:0] int_value;
    logic               overflowed;
    logic               last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } token_pair_t;

endpackage

`default_nettype wire

[rtl/jts_step.sv]
// Scanner state register and the per-byte token logic.
`default_nettype none

module jts_step
  import jts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire logic [7:0]  byte_in,
  input  wire logic        is_last,
  output token_pair_t      tokens
);

  localparam scan_state_t IDLE_STATE = '{mode: MODE_IDLE, skip: 3'd0, acc: 32'd0,
                                         neg: 1'b0, sat: 1'b0};

  scan_state_t st_r, st_nxt;

  token_t     cand_a, cand_b, cand_c;
  logic       a_v, b_v, c_v;
  logic       is_dig;
  logic [3:0] dig;
  logic [35:0] prod;
  logic [31:0] limit;

  function automatic logic pending_valid(input scan_state_t s);
    return (s.mode == MODE_NUMBER) || (s.mode == MODE_MINUS);
  endfunction

  function automatic token_t pending_tok(input scan_state_t s);
    token_t t;
    t = '0;
    if (s.mode == MODE_NUMBER) begin
      t.kind       = KIND_INT;
      t.int_value  = s.neg ? (32'd0 - s.acc) : s.acc;
      t.overflowed = s.sat;
    end else begin
      t.kind       = KIND_CHAR;
      t.char_value = CH_MINUS;
    end
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE_STATE;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    logic fresh;
    st_nxt = st_r;
    cand_a = pending_tok(st_r);
    cand_b = '0;
    cand_c = '0;
    a_v    = 1'b0;
    b_v    = 1'b0;
    c_v    = 1'b0;
    fresh  = 1'b0;
    is_dig = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    dig    = 4'(byte_in - CH_ZERO);
    prod   = {4'd0, st_r.acc} * 36'(RADIX) + 36'(dig);
    limit  = st_r.neg ? NEG_LIMIT : POS_LIMIT;

    if (byte_in == CH_NUL) begin
      a_v    = pending_valid(st_r);
      st_nxt = IDLE_STATE;
    end else begin
      unique case (st_r.mode)
        MODE_STRING: begin
          b_v = 1'b1;
          if (byte_in == CH_QUOTE) begin
            cand_b.kind = KIND_STR_END;
            st_nxt      = IDLE_STATE;
          end else begin
            cand_b.kind       = KIND_STR_CHAR;
            cand_b.char_value = byte_in;
          end
        end
        MODE_SKIP: begin
          if (st_r.skip > 3'd1) st_nxt.skip = st_r.skip - 3'd1;
          else                  st_nxt = IDLE_STATE;
        end
        MODE_NUMBER: begin
          if (is_dig) begin
            if (!st_r.sat) begin
              if (prod > {4'd0, limit}) begin
                st_nxt.acc = limit;
                st_nxt.sat = 1'b1;
              end else begin
                st_nxt.acc = prod[31:0];
              end
            end
          end else begin
            a_v   = 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (is_dig) begin
            st_nxt.mode = MODE_NUMBER;
            st_nxt.acc  = 32'(dig);
            st_nxt.neg  = 1'b1;
            st_nxt.sat  = 1'b0;
          end else begin
            a_v   = 1'b1;
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        st_nxt = IDLE_STATE;
        if (byte_in == CH_SPACE) begin
          st_nxt = IDLE_STATE;
        end else if (byte_in == CH_QUOTE) begin
          st_nxt.mode = MODE_STRING;
        end else if (is_dig) begin
          st_nxt.mode = MODE_NUMBER;
          st_nxt.acc  = 32'(dig);
        end else if (byte_in == CH_MINUS) begin
          st_nxt.mode = MODE_MINUS;
        end else if (byte_in == CH_T) begin
          b_v         = 1'b1;
          cand_b.kind = KIND_TRUE;
          st_nxt.mode = MODE_SKIP;
          st_nxt.skip = SKIP_TRUE;
        end else if (byte_in == CH_F) begin
          b_v         = 1'b1;
          cand_b.kind = KIND_FALSE;
          st_nxt.mode = MODE_SKIP;
          st_nxt.skip = SKIP_FALSE;
        end else begin
          b_v               = 1'b1;
          cand_b.kind       = KIND_CHAR;
          cand_b.char_value = byte_in;
        end
      end

      // Final byte: flush whatever number or minus is still open
      if (is_last) begin
        c_v    = pending_valid(st_nxt);
        cand_c = pending_tok(st_nxt);
        st_nxt = IDLE_STATE;
      end
    end
  end

  // Pack the candidates in order; at most two are ever valid together
  always_comb begin
    tokens      = '0;
    tokens.n    = 2'(a_v) + 2'(b_v) + 2'(c_v);
    tokens.tok0 = a_v ? cand_a : (b_v ? cand_b : cand_c);
    tokens.tok1 = (a_v && b_v) ? cand_b : cand_c;
    if (tokens.n == 2'd1) tokens.tok0.last_of_run = 1'b1;
    else                  tokens.tok1.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

[rtl/jts_queue.sv]
// Small result queue: takes up to two tokens a cycle, hands out one.
`default_nettype none

module jts_queue
  import jts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire token_pair_t tokens,
  input  wire logic        pop,
  output token_t           head,
  output logic [QAW:0]     count
);

  token_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic [1:0]       n_push;

  assign n_push = push ? tokens.n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(n_push);
      rd_ptr_r <= rd_ptr_r + QAW'(pop);
      count_r  <= count_r + (QAW+1)'(n_push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r] <= tokens.tok0;
    if (n_push == 2'd2) mem_r[wr_ptr_r + QAW'(1)] <= tokens.tok1;
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

[rtl/json_token_scanner.sv]
// Top level of the byte-serial JSON token scanner.
//
// Usage: feed one text byte per input transaction (in_byte_in, in_is_last)
// with in_valid; the block holds it off with in_stall. Each byte yields zero,
// one or two token transactions on the out_ channel; out_last_of_run marks
// the last token caused by a byte. A zero byte or in_is_last closes any
// pending number or minus and returns the scanner to idle.
//
// Timing: an accepted byte waits in the input register, where the scan logic
// updates the mode and writes its tokens into a four-entry result queue;
// the first token is then offered straight from the queue head.
// Throughput: one byte per cycle while the receiver drains one token per
// cycle and each byte gives at most one token; the result queue has a single
// output port, so bytes that give two tokens add to the drain.
// Stalling: when out_stall holds the queue, the input register stops
// advancing once fewer than two queue entries are free, and in_stall rises
// while it holds a byte. No transaction is lost or repeated.
// Reset: synchronous active-low rst_n clears the mode, the number state,
// the queue pointers and the input register valid bit.
`default_nettype none

module json_token_scanner
  import jts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte_in,
  input  wire logic               in_is_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_token_kind,
  output logic [7:0]              out_char_value,
  output logic signed [31:0]      out_int_value,
  output logic                    out_overflowed,
  output logic                    out_last_of_run
);

  // Input register
  logic        stg_valid_r, stg_valid_nxt;
  logic [7:0]  stg_byte_r;
  logic        stg_last_r;

  logic        in_take;
  logic        advance;
  logic        room;
  logic        pop;
  token_pair_t tokens;
  token_t      head;
  logic [QAW:0] q_count;

  // Advance only when the queue can take a worst-case pair of tokens
  assign room    = (QDEPTH - int'(q_count) + int'(pop)) >= 2;
  assign advance = stg_valid_r && room;
  assign in_stall = stg_valid_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_take)      stg_valid_nxt = 1'b1;
    else if (advance) stg_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  // Payload needs no reset; load on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_byte_in;
      stg_last_r <= in_is_last;
    end
  end

  jts_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (stg_byte_r),
    .is_last (stg_last_r),
    .tokens  (tokens)
  );

  jts_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (advance),
    .tokens (tokens),
    .pop    (pop),
    .head   (head),
    .count  (q_count)
  );

  // Drive the result channel straight from the queue head
  assign out_valid       = (q_count != '0);
  assign pop             = out_valid && !out_stall;
  assign out_token_kind  = head.kind;
  assign out_char_value  = head.char_value;
  assign out_int_value   = head.int_value;
  assign out_overflowed  = head.overflowed;
  assign out_last_of_run = head.last_of_run;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(q_count) <= QDEPTH)
    else $error("result queue count beyond depth");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !advance |=> stg_valid_r && $stable(stg_byte_r) && $stable(stg_last_r))
    else $error("held input byte lost or changed");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (tokens.n != 2'd0) |=> out_valid)
    else $error("pushed tokens not offered");
`endif

endmodule

`default_nettype wire

[verif/jts_checker.sv]
// Token stream predictor and comparator for the JSON token scanner.
`default_nettype none

module jts_checker
  import jts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [7:0]         in_byte_in,
  input  wire logic               in_is_last,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [2:0]         out_token_kind,
  input  wire logic [7:0]         out_char_value,
  input  wire logic signed [31:0] out_int_value,
  input  wire logic               out_overflowed,
  input  wire logic               out_last_of_run,
  output int                      fail_count,
  output int                      tokens_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow scan state
  scan_mode_t  mode_q;
  logic [2:0]  skip_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic        sat_q;

  token_t due_q[$];   // tokens predicted, not yet seen
  token_t run_q[$];   // tokens of the byte being scanned

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void emit_token(input token_kind_t k, input logic [7:0] ch,
                                     input logic [31:0] v, input logic ovf);
    token_t t;
    if (run_q.size() >= 2) return;
    t.kind        = k;
    t.char_value  = ch;
    t.int_value   = v;
    t.overflowed  = ovf;
    t.last_of_run = 1'b0;
    run_q.push_back(t);
  endfunction

  function automatic void return_idle();
    mode_q = MODE_IDLE;
    skip_q = '0;
    mag_q  = '0;
    neg_q  = 1'b0;
    sat_q  = 1'b0;
  endfunction

  function automatic void open_number(input logic [7:0] c, input logic neg);
    mode_q = MODE_NUMBER;
    mag_q  = {24'd0, 8'(c - CH_ZERO)};
    neg_q  = neg;
    sat_q  = 1'b0;
  endfunction

  function automatic void close_pending();
    if (mode_q == MODE_NUMBER) begin
      emit_token(KIND_INT, 8'd0, neg_q ? (32'd0 - mag_q) : mag_q, sat_q);
    end else if (mode_q == MODE_MINUS) begin
      emit_token(KIND_CHAR, CH_MINUS, 32'd0, 1'b0);
    end
  endfunction

  function automatic void start_fresh(input logic [7:0] c);
    return_idle();
    if (c == CH_SPACE) begin
      return;
    end else if (c == CH_QUOTE) begin
      mode_q = MODE_STRING;
    end else if (is_digit(c)) begin
      open_number(c, 1'b0);
    end else if (c == CH_MINUS) begin
      mode_q = MODE_MINUS;
    end else if (c == CH_T) begin
      emit_token(KIND_TRUE, 8'd0, 32'd0, 1'b0);
      mode_q = MODE_SKIP;
      skip_q = SKIP_TRUE;
    end else if (c == CH_F) begin
      emit_token(KIND_FALSE, 8'd0, 32'd0, 1'b0);
      mode_q = MODE_SKIP;
      skip_q = SKIP_FALSE;
    end else begin
      emit_token(KIND_CHAR, c, 32'd0, 1'b0);
    end
  endfunction

  // Advance the shadow state by one byte and queue the tokens it yields.
  function automatic void scan_byte(input logic [7:0] c, input logic last);
    logic [63:0] grown;
    logic [31:0] ceiling;
    token_t      t;
    run_q.delete();
    if (c == CH_NUL) begin
      close_pending();
      return_idle();
    end else begin
      case (mode_q)
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            emit_token(KIND_STR_END, 8'd0, 32'd0, 1'b0);
            return_idle();
          end else begin
            emit_token(KIND_STR_CHAR, c, 32'd0, 1'b0);
          end
        end
        MODE_SKIP: begin
          if (skip_q > 3'd1) skip_q = skip_q - 3'd1;
          else return_idle();
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            if (!sat_q) begin
              ceiling = neg_q ? NEG_LIMIT : POS_LIMIT;
              grown   = {32'd0, mag_q} * {60'd0, RADIX} + {56'd0, 8'(c - CH_ZERO)};
              if (grown > {32'd0, ceiling}) begin
                mag_q = ceiling;
                sat_q = 1'b1;
              end else begin
                mag_q = grown[31:0];
              end
            end
          end else begin
            close_pending();
            start_fresh(c);
          end
        end
        MODE_MINUS: begin
          if (is_digit(c)) begin
            open_number(c, 1'b1);
          end else begin
            close_pending();
            start_fresh(c);
          end
        end
        default: start_fresh(c);
      endcase
      if (last) begin
        close_pending();
        return_idle();
      end
    end
    if (run_q.size() > 0) begin
      t = run_q.pop_back();
      t.last_of_run = 1'b1;
      run_q.push_back(t);
    end
    foreach (run_q[i]) due_q.push_back(run_q[i]);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("jts_checker: %s mismatch, got 0x%08h, expected 0x%08h at %0t",
             what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      due_q.delete();
      return_idle();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report("unexpected token", {29'd0, out_token_kind}, 32'd0);
        end else begin
          want = due_q.pop_front();
          if (out_token_kind != want.kind)
            report("token_kind", {29'd0, out_token_kind}, {29'd0, want.kind});
          if (out_char_value != want.char_value)
            report("char_value", {24'd0, out_char_value}, {24'd0, want.char_value});
          if (out_int_value != want.int_value)
            report("int_value", out_int_value, want.int_value);
          if (out_overflowed != want.overflowed)
            report("overflowed", {31'd0, out_overflowed}, {31'd0, want.overflowed});
          if (out_last_of_run != want.last_of_run)
            report("last_of_run", {31'd0, out_last_of_run}, {31'd0, want.last_of_run});
        end
      end
      if (in_valid && !in_stall) scan_byte(in_byte_in, in_is_last);
    end
    tokens_due = due_q.size();
  end

endmodule

`default_nettype wire

[verif/tb.sv]
// Stimulus and verdict for the JSON token scanner.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jts_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  localparam int TEXT_BYTES  = 1000;    // random text length, in bytes
  localparam int LONG_HOLD   = 400;     // cycles of a long receiver hold-off
  localparam int CALM_ITEMS  = 80;      // gapless bytes offered during a hold-off

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte_in;
  logic               in_is_last;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_token_kind;
  logic [7:0]         out_char_value;
  logic signed [31:0] out_int_value;
  logic               out_overflowed;
  logic               out_last_of_run;

  int fail_count;
  int tokens_due;

  int burst_left;      // bytes left in the current burst
  int calm_left;       // bytes to offer back to back, no gaps
  int bytes_sent;
  int hold_reqs;       // long hold-offs asked of the receiver so far

  json_token_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_in     (in_byte_in),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_char_value (out_char_value),
    .out_int_value  (out_int_value),
    .out_overflowed (out_overflowed),
    .out_last_of_run(out_last_of_run)
  );

  jts_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_in     (in_byte_in),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_char_value (out_char_value),
    .out_int_value  (out_int_value),
    .out_overflowed (out_overflowed),
    .out_last_of_run(out_last_of_run),
    .fail_count     (fail_count),
    .tokens_due     (tokens_due)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  // Receiver: stall in segments of random style; honor a long hold-off when
  // asked, counting its cycles here so the sender keeps pushing meanwhile.
  initial begin
    int           seg_left;
    int           hold_left;
    int           holds_served;
    stall_style_t style;
    out_stall    = 1'b0;
    seg_left     = 0;
    hold_left    = 0;
    holds_served = 0;
    style        = STALL_NONE;
    forever begin
      @(posedge clk);
      if (holds_served != hold_reqs) begin
        holds_served = hold_reqs;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          style    = stall_style_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Offer one byte and hold it until the transaction is accepted. Between
  // bursts, drop valid for a random gap; keep valid high inside a burst.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
    in_valid   <= 1'b1;
    in_byte_in <= c;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Quoted string with random content; now and then leave it unclosed.
  task automatic send_string();
    int         n;
    logic [7:0] c;
    send_byte(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 6);
    repeat (n) begin
      c = 8'($urandom_range(1, 255));
      if (c == CH_QUOTE) c = CH_SPACE;
      send_byte(c, 1'b0);
    end
    if ($urandom_range(0, 7) != 0) send_byte(CH_QUOTE, ($urandom_range(0, 15) == 0));
  endtask

  // Integer with optional sign; aim often at the saturation boundaries.
  task automatic send_number();
    string   digits;
    longint  mag;
    int      n;
    int      pick;
    string   enders;
    if ($urandom_range(0, 2) == 0) send_byte(CH_MINUS, 1'b0);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      n      = $urandom_range(1, 4);
      digits = "";
      repeat (n) digits = {digits, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    end else if (pick < 8) begin
      case ($urandom_range(0, 5))
        0:       mag = 64'd2147483647;
        1:       mag = 64'd2147483648;
        2:       mag = 64'd2147483649;
        3:       mag = 64'd4294967295;
        4:       mag = 64'd214748364;
        default: mag = 64'd999999999999;
      endcase
      digits = $sformatf("%0d", mag);
    end else begin
      n      = $urandom_range(10, 13);
      digits = "";
      repeat (n) digits = {digits, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    end
    for (int i = 0; i < digits.len() - 1; i++) send_byte(digits[i], 1'b0);
    // End on the last flag, a zero byte, or whatever terminator follows.
    pick = $urandom_range(0, 7);
    send_byte(digits[digits.len() - 1], (pick == 0));
    enders = ",]} \":t";
    if (pick == 1) send_byte(CH_NUL, 1'b0);
    else if (pick > 1) send_byte(enders[$urandom_range(0, enders.len() - 1)], 1'b0);
  endtask

  // true / false followed by skipped bytes, usually the letters, sometimes junk.
  task automatic send_literal();
    string word;
    word = ($urandom_range(0, 1) == 0) ? "true" : "false";
    send_byte(word[0], 1'b0);
    for (int i = 1; i < word.len(); i++) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      else if ($urandom_range(0, 19) == 0) send_byte(word[i], 1'b1);
      else send_byte(word[i], 1'b0);
    end
  endtask

  initial begin
    string punct;
    int    pick;
    bit    first_hold_done;
    bit    second_hold_done;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_in    = CH_NUL;
    in_is_last    = 1'b0;
    burst_left    = 0;
    calm_left     = 0;
    bytes_sent    = 0;
    hold_reqs     = 0;
    punct         = "{}[],: ";
    first_hold_done  = 1'b0;
    second_hold_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text: string with a top byte, both literals, negative number
    // ending in a quote, zero-byte flush, lone minus, last-flag flushes.
    send_text("\"");
    send_byte(8'hFF, 1'b0);
    send_text("\"true");
    send_text("false");
    send_text("-7\"\"");
    send_text("42");
    send_byte(CH_NUL, 1'b0);
    send_text("-, ");
    send_byte(CH_ZERO + 8'd3, 1'b1);
    send_byte(CH_MINUS, 1'b1);
    send_byte(8'h01, 1'b0);

    // Random text, mostly well-formed fragments with some noise.
    while (bytes_sent < TEXT_BYTES) begin
      if (!first_hold_done && bytes_sent >= 300) begin
        first_hold_done = 1'b1;
        hold_reqs++;
        calm_left       = CALM_ITEMS;
      end
      if (!second_hold_done && bytes_sent >= 700) begin
        second_hold_done = 1'b1;
        hold_reqs++;
        calm_left        = CALM_ITEMS;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) send_string();
      else if (pick < 50) send_number();
      else if (pick < 62) send_literal();
      else if (pick < 80) send_byte(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
      else if (pick < 85) begin
        send_byte(CH_MINUS, 1'b0);
        send_byte(punct[$urandom_range(0, punct.len() - 1)], ($urandom_range(0, 3) == 0));
      end else if (pick < 88) send_byte(CH_NUL, ($urandom_range(0, 1) == 0));
      else send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
    end
    in_valid <= 1'b0;

    // Drain: sample the checker on falling edges to stay clear of its update.
    @(negedge clk);
    while (tokens_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && tokens_due == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/jts_pkg.sv
rtl/jts_step.sv
rtl/jts_queue.sv
rtl/json_token_scanner.sv
verif/jts_checker.sv
verif/tb.sv
